>>> rtl/piece_block_tracker_and_picker_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef PIECE_BLOCK_TRACKER_AND_PICKER_UNIT_ASSERT_SVH
`define PIECE_BLOCK_TRACKER_AND_PICKER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBTP_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pbtp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PBTP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pbtp assertion failed");

`endif

>>> rtl/pbtp_pkg.sv
`default_nettype none

package pbtp_pkg;

  localparam int MAX_PIECES       = 64;
  localparam int BLOCKS_PER_PIECE = 16;
  localparam int BLOCK_BYTES      = 16 * 1024;

  localparam int PIECE_W     = $clog2(MAX_PIECES);
  localparam int CNT_W       = $clog2(MAX_PIECES + 1);
  localparam int BLK_W       = $clog2(BLOCKS_PER_PIECE);
  localparam int NB_W        = $clog2(BLOCKS_PER_PIECE + 1);
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int MAX_SIZE    = BLOCKS_PER_PIECE * BLOCK_BYTES;

  // Fixed field widths of the channels and registers
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 19;
  localparam int OFF_W    = 18;
  localparam int LEN_W    = 15;
  localparam int MAP_W    = 64;
  localparam int CFG_IX_W = 2;
  localparam int CFG_W    = 19;

  localparam logic [CNT_W-1:0]  CFG_PIECES_RESET = CNT_W'(64);
  localparam logic [SIZE_W-1:0] CFG_BYTES_RESET  = SIZE_W'(262144);

  localparam logic [CFG_IX_W-1:0] REG_PIECE_COUNT = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_PIECE_BYTES = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_LAST_BYTES  = 2'd2;

  localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_VERDICT = 2'd2;

  localparam logic [1:0] OUT_ACCEPTED = 2'd0;
  localparam logic [1:0] OUT_REJECTED = 2'd1;
  localparam logic [1:0] OUT_FOUND    = 2'd2;
  localparam logic [1:0] OUT_NONE     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_SCAN,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [PIECE_W-1:0] piece_index;
    logic [OFF_W-1:0]   begin_offset;
    logic [LEN_W-1:0]   block_bytes;
    logic [MAP_W-1:0]   peer_pieces;
    logic               hash_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               piece_full;
    logic [PIECE_W-1:0] req_piece;
    logic [OFF_W-1:0]   req_begin;
    logic [LEN_W-1:0]   req_length;
    logic [MAP_W-1:0]   have_map;
    logic [CNT_W-1:0]   done_pieces;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic scan_init;
    logic rd_item;
    logic scan_run;
    logic eval_item;
    logic scan_done;
    logic send;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            hit;
    logic            scan_end;
    logic            out_free;
  } sts_t;

  typedef struct packed {
    logic             found;
    logic [BLK_W-1:0] idx;
  } free_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(MAX_SIZE)) r = SIZE_W'(MAX_SIZE);
    return r;
  endfunction

  // Round up to whole blocks, capped at the bitmap width
  function automatic logic [NB_W-1:0] blocks_of(input logic [SIZE_W-1:0] s);
    logic [SIZE_W:0]             t;
    logic [SIZE_W-BLOCK_SHIFT:0] q;
    logic [NB_W-1:0]             r;
    t = {1'b0, s} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
    q = t[SIZE_W:BLOCK_SHIFT];
    if (q > (SIZE_W - BLOCK_SHIFT + 1)'(BLOCKS_PER_PIECE)) r = NB_W'(BLOCKS_PER_PIECE);
    else r = NB_W'(q);
    return r;
  endfunction

  function automatic logic [NB_W-1:0] count_seen(input logic [BLOCKS_PER_PIECE-1:0] m);
    return NB_W'($countones(m));
  endfunction

  // Lowest clear bit below nb
  function automatic free_t first_free(input logic [BLOCKS_PER_PIECE-1:0] m,
                                       input logic [NB_W-1:0] nb);
    free_t r;
    r = '0;
    for (int b = BLOCKS_PER_PIECE - 1; b >= 0; b--) begin
      if (!m[b] && (NB_W'(b) < nb)) begin
        r.found = 1'b1;
        r.idx   = BLK_W'(b);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pbtp_ifs.sv
`default_nettype none

interface pbtp_in_if;
  logic                          valid;
  logic                          ready;
  logic [pbtp_pkg::OP_W-1:0]     opcode;
  logic [pbtp_pkg::PIECE_W-1:0]  piece_index;
  logic [pbtp_pkg::OFF_W-1:0]    begin_offset;
  logic [pbtp_pkg::LEN_W-1:0]    block_bytes;
  logic [pbtp_pkg::MAP_W-1:0]    peer_pieces;
  logic                          hash_ok;

  modport source (output valid, opcode, piece_index, begin_offset, block_bytes,
                  peer_pieces, hash_ok, input ready);
  modport sink (input valid, opcode, piece_index, begin_offset, block_bytes,
                peer_pieces, hash_ok, output ready);
endinterface

interface pbtp_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    outcome;
  logic                          piece_full;
  logic [pbtp_pkg::PIECE_W-1:0]  req_piece;
  logic [pbtp_pkg::OFF_W-1:0]    req_begin;
  logic [pbtp_pkg::LEN_W-1:0]    req_length;
  logic [pbtp_pkg::MAP_W-1:0]    have_map;
  logic [pbtp_pkg::CNT_W-1:0]    done_pieces;

  modport source (output valid, outcome, piece_full, req_piece, req_begin, req_length,
                  have_map, done_pieces, input ready);
  modport sink (input valid, outcome, piece_full, req_piece, req_begin, req_length,
                have_map, done_pieces, output ready);
endinterface

`default_nettype wire

>>> rtl/pbtp_ctrl.sv
`default_nettype none

module pbtp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pbtp_pkg::sts_t sts,
  output pbtp_pkg::cmd_t      cmd
);

  pbtp_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign in_ready = (state_r == pbtp_pkg::ST_IDLE) && rst_n;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbtp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbtp_pkg::ST_IDLE: begin
        if (accept) begin
          if (sts.opcode == pbtp_pkg::OP_REQUEST) state_nxt = pbtp_pkg::ST_SCAN;
          else state_nxt = pbtp_pkg::ST_LOOK;
        end
      end
      pbtp_pkg::ST_LOOK: state_nxt = pbtp_pkg::ST_EVAL;
      pbtp_pkg::ST_EVAL: state_nxt = pbtp_pkg::ST_SEND;
      pbtp_pkg::ST_SCAN: begin
        if (sts.hit || sts.scan_end) state_nxt = pbtp_pkg::ST_SEND;
      end
      pbtp_pkg::ST_SEND: begin
        if (sts.out_free) state_nxt = pbtp_pkg::ST_IDLE;
      end
      default: state_nxt = pbtp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      pbtp_pkg::ST_IDLE: begin
        cmd.latch     = accept;
        cmd.scan_init = accept && (sts.opcode == pbtp_pkg::OP_REQUEST);
      end
      pbtp_pkg::ST_LOOK: cmd.rd_item = 1'b1;
      pbtp_pkg::ST_EVAL: cmd.eval_item = 1'b1;
      pbtp_pkg::ST_SCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_done = sts.hit || sts.scan_end;
      end
      pbtp_pkg::ST_SEND: cmd.send = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pbtp_dpath.sv
`default_nettype none

module pbtp_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pbtp_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic [pbtp_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire pbtp_pkg::in_item_t            in_item,
  input  wire pbtp_pkg::cmd_t                cmd,
  output pbtp_pkg::sts_t                     sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output pbtp_pkg::out_item_t                out_item
);

  localparam int PW = pbtp_pkg::PIECE_W;
  localparam int BP = pbtp_pkg::BLOCKS_PER_PIECE;

  logic [pbtp_pkg::CNT_W-1:0]  pc_r;
  logic [pbtp_pkg::SIZE_W-1:0] pb_r, lpb_r;

  pbtp_pkg::in_item_t          item_r;
  logic [pbtp_pkg::MAP_W-1:0]  have_r, have_nxt;
  logic [pbtp_pkg::CNT_W-1:0]  total_r, total_nxt;

  // Per-piece block bitmap; an entry never written reads as empty
  logic [BP-1:0]               seen_mem [pbtp_pkg::MAX_PIECES];
  logic [pbtp_pkg::MAX_PIECES-1:0] vld_r;
  logic [BP-1:0]               rd_q_r;
  logic                        rd_qv_r;
  logic [PW-1:0]               rd_idx_r;
  logic                        rd_vld_r;
  logic [PW-1:0]               scan_idx_r;
  logic                        more_r;

  pbtp_pkg::out_item_t         res_r, res_nxt;
  pbtp_pkg::out_item_t         out_r;
  logic                        out_valid_r;

  logic [pbtp_pkg::CNT_W-1:0]  n_use;
  logic [PW-1:0]               last_idx;
  logic                        rd_en;
  logic [PW-1:0]               rd_addr;
  logic                        mem_we;
  logic [BP-1:0]               mem_wd;

  logic [BP-1:0]               seen;
  logic [pbtp_pkg::SIZE_W-1:0] e_size;
  logic [pbtp_pkg::NB_W-1:0]   e_nb;
  logic                        e_have, e_in;
  logic [pbtp_pkg::BLK_W-1:0]  bi;
  logic [pbtp_pkg::SIZE_W-1:0] span;
  logic                        rx_ok, rx_full, vd_ok;
  logic [BP-1:0]               rx_seen;
  pbtp_pkg::free_t             ff;
  logic                        cand;
  logic [pbtp_pkg::OFF_W-1:0]  off;
  logic [pbtp_pkg::SIZE_W-1:0] rem;
  logic [pbtp_pkg::LEN_W-1:0]  rlen;
  logic                        out_free;

  always_comb begin
    if (pc_r == '0) n_use = pbtp_pkg::CNT_W'(1);
    else if (pc_r > pbtp_pkg::CNT_W'(pbtp_pkg::MAX_PIECES))
      n_use = pbtp_pkg::CNT_W'(pbtp_pkg::MAX_PIECES);
    else n_use = pc_r;
  end
  assign last_idx = PW'(n_use - pbtp_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= pbtp_pkg::CFG_PIECES_RESET;
      pb_r  <= pbtp_pkg::CFG_BYTES_RESET;
      lpb_r <= pbtp_pkg::CFG_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbtp_pkg::REG_PIECE_COUNT: pc_r  <= cfg_wdata[pbtp_pkg::CNT_W-1:0];
        pbtp_pkg::REG_PIECE_BYTES: pb_r  <= cfg_wdata[pbtp_pkg::SIZE_W-1:0];
        pbtp_pkg::REG_LAST_BYTES:  lpb_r <= cfg_wdata[pbtp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
  end

  assign rd_en   = cmd.rd_item || (cmd.scan_run && more_r);
  assign rd_addr = cmd.rd_item ? item_r.piece_index : scan_idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) seen_mem[rd_idx_r] <= mem_wd;
    if (rd_en) rd_q_r <= seen_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_qv_r    <= 1'b0;
      rd_idx_r   <= '0;
      rd_vld_r   <= 1'b0;
      scan_idx_r <= '0;
      more_r     <= 1'b0;
    end else begin
      if (mem_we) vld_r[rd_idx_r] <= 1'b1;
      if (rd_en) begin
        rd_qv_r  <= vld_r[rd_addr];
        rd_idx_r <= rd_addr;
      end
      if (cmd.scan_init) begin
        scan_idx_r <= '0;
        more_r     <= 1'b1;
        rd_vld_r   <= 1'b0;
      end else if (cmd.scan_run) begin
        // issue the next piece while the previous one is judged
        rd_vld_r <= more_r;
        if (more_r) begin
          scan_idx_r <= scan_idx_r + PW'(1);
          more_r     <= (scan_idx_r != last_idx);
        end
      end
    end
  end

  // Evaluation of the piece whose bitmap sits in the read register
  assign seen   = rd_qv_r ? rd_q_r : '0;
  assign e_size = pbtp_pkg::clamp_size((rd_idx_r == last_idx) ? lpb_r : pb_r);
  assign e_nb   = pbtp_pkg::blocks_of(e_size);
  assign e_have = have_r[rd_idx_r];
  assign e_in   = pbtp_pkg::CNT_W'(rd_idx_r) < n_use;

  assign bi      = item_r.begin_offset[pbtp_pkg::OFF_W-1:pbtp_pkg::BLOCK_SHIFT];
  assign span    = pbtp_pkg::SIZE_W'(item_r.begin_offset) +
                   pbtp_pkg::SIZE_W'(item_r.block_bytes);
  assign rx_ok   = e_in && !e_have && (span <= e_size) && (pbtp_pkg::NB_W'(bi) < e_nb);
  assign rx_seen = seen | (BP'(1) << bi);
  assign rx_full = pbtp_pkg::count_seen(rx_seen) == e_nb;
  assign vd_ok   = e_in && !e_have && (pbtp_pkg::count_seen(seen) == e_nb);

  assign ff   = pbtp_pkg::first_free(seen, e_nb);
  assign cand = !e_have && item_r.peer_pieces[rd_idx_r] && ff.found;
  assign off  = pbtp_pkg::OFF_W'(ff.idx) << pbtp_pkg::BLOCK_SHIFT;
  assign rem  = e_size - pbtp_pkg::SIZE_W'(off);
  assign rlen = (rem > pbtp_pkg::SIZE_W'(pbtp_pkg::BLOCK_BYTES)) ?
                pbtp_pkg::LEN_W'(pbtp_pkg::BLOCK_BYTES) : rem[pbtp_pkg::LEN_W-1:0];

  always_comb begin
    have_nxt  = have_r;
    total_nxt = total_r;
    mem_we    = 1'b0;
    mem_wd    = rx_seen;
    res_nxt   = res_r;
    if (cmd.eval_item) begin
      res_nxt         = '0;
      res_nxt.outcome = pbtp_pkg::OUT_REJECTED;
      priority case (item_r.opcode)
        pbtp_pkg::OP_RECEIVE: begin
          if (rx_ok) begin
            mem_we             = 1'b1;
            res_nxt.outcome    = pbtp_pkg::OUT_ACCEPTED;
            res_nxt.piece_full = rx_full;
          end
        end
        pbtp_pkg::OP_VERDICT: begin
          if (vd_ok) begin
            res_nxt.outcome = pbtp_pkg::OUT_ACCEPTED;
            if (item_r.hash_ok) begin
              have_nxt[rd_idx_r] = 1'b1;
              total_nxt          = total_r + pbtp_pkg::CNT_W'(1);
            end else begin
              // failed digest: drop every block of the piece
              mem_we = 1'b1;
              mem_wd = '0;
            end
          end
        end
        default: ;
      endcase
      res_nxt.have_map    = have_nxt;
      res_nxt.done_pieces = total_nxt;
    end else if (cmd.scan_done) begin
      res_nxt = '0;
      if (sts.hit) begin
        res_nxt.outcome    = pbtp_pkg::OUT_FOUND;
        res_nxt.req_piece  = rd_idx_r;
        res_nxt.req_begin  = off;
        res_nxt.req_length = rlen;
      end else begin
        res_nxt.outcome = pbtp_pkg::OUT_NONE;
      end
      res_nxt.have_map    = have_r;
      res_nxt.done_pieces = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= '0;
      total_r <= '0;
    end else begin
      have_r  <= have_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.send) out_r <= res_r;
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.opcode   = cmd.latch ? in_item.opcode : in_item.opcode;
  assign sts.hit      = rd_vld_r && cand;
  assign sts.scan_end = rd_vld_r && (rd_idx_r == last_idx);
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> rtl/piece_block_tracker_and_picker_unit.sv
// Piece and block tracker with next-block picker.
// Input channel in_ch carries one item: receive (mark a block of a piece),
// request (pick the next block to ask a peer for) or hash verdict. Every
// item gives exactly one result item on out_ch, with the complete-piece map
// and count as they stand after the item.
// Configuration: cfg_we, cfg_index, cfg_wdata write piece_count, piece_bytes
// and last_piece_bytes; write only while no item is in flight.
// Timing: one item at a time. A receive or verdict reads the piece's block
// bitmap from the on-chip memory, updates it and then shows its result once
// the output register is free. A request walks the pieces through the same
// memory read port, one piece per cycle, pipelined one deep; it looks at 1 to
// piece_count pieces, at most 64.
// A new item is taken once the previous one has reached the output register,
// so a stalled receiver holds one finished result while the next item runs;
// the one after that waits until out_ch drains.
// Reset (synchronous, rst_n low) restores the register defaults, clears all
// block bitmaps through per-piece valid bits and drops any pending result.
`default_nettype none

module piece_block_tracker_and_picker_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pbtp_in_if.sink                            in_ch,
  pbtp_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [pbtp_pkg::CFG_IX_W-1:0] cfg_index,
  input  wire logic [pbtp_pkg::CFG_W-1:0]    cfg_wdata
);

  pbtp_pkg::in_item_t  in_item;
  pbtp_pkg::out_item_t out_item;
  pbtp_pkg::cmd_t      cmd;
  pbtp_pkg::sts_t      sts;
  logic                in_ready;
  logic                out_valid;

  assign in_item.opcode       = in_ch.opcode;
  assign in_item.piece_index  = in_ch.piece_index;
  assign in_item.begin_offset = in_ch.begin_offset;
  assign in_item.block_bytes  = in_ch.block_bytes;
  assign in_item.peer_pieces  = in_ch.peer_pieces;
  assign in_item.hash_ok      = in_ch.hash_ok;
  assign in_ch.ready          = in_ready;

  pbtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbtp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.outcome     = out_item.outcome;
  assign out_ch.piece_full  = out_item.piece_full;
  assign out_ch.req_piece   = out_item.req_piece;
  assign out_ch.req_begin   = out_item.req_begin;
  assign out_ch.req_length  = out_item.req_length;
  assign out_ch.have_map    = out_item.have_map;
  assign out_ch.done_pieces = out_item.done_pieces;

endmodule

`default_nettype wire

>>> rtl/pbtp_chk.sv
`default_nettype none
`include "piece_block_tracker_and_picker_unit_assert.svh"

module pbtp_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [1:0]                   outcome,
  input wire logic [pbtp_pkg::PIECE_W-1:0] req_piece,
  input wire logic [pbtp_pkg::OFF_W-1:0]   req_begin,
  input wire logic [pbtp_pkg::LEN_W-1:0]   req_length,
  input wire logic [pbtp_pkg::MAP_W-1:0]   have_map,
  input wire logic [pbtp_pkg::CNT_W-1:0]   done_pieces
);

  // hold a stalled result
  `PBTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(have_map) && $stable(done_pieces))

  // one item at a time: busy right after an acceptance
  `PBTP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // complete count tracks the complete map
  `PBTP_ASSERT_SAME(a_count_map, clk, rst_n, out_valid, $countones(have_map) == done_pieces)

  // request fields only on a found request, and then a real block length
  `PBTP_ASSERT_SAME(a_req_fields, clk, rst_n, out_valid, (outcome == pbtp_pkg::OUT_FOUND) ? (req_length != 0 && req_length <= pbtp_pkg::BLOCK_BYTES) : (req_piece == 0 && req_begin == 0 && req_length == 0))

endmodule

bind piece_block_tracker_and_picker_unit pbtp_chk u_pbtp_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .outcome     (out_ch.outcome),
  .req_piece   (out_ch.req_piece),
  .req_begin   (out_ch.req_begin),
  .req_length  (out_ch.req_length),
  .have_map    (out_ch.have_map),
  .done_pieces (out_ch.done_pieces)
);

`default_nettype wire
